// ===== rtl/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// Types and constants shared by the TGA 24-bit stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

    localparam int unsigned HDR_CNT_W = 5;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_POS   = 5'd17;
    localparam logic [HDR_CNT_W-1:0] HDR_DONE_COUNT = 5'd18;
    localparam logic [HDR_CNT_W-1:0] HDR_POS_TYPE   = 5'd2;
    localparam logic [HDR_CNT_W-1:0] HDR_POS_W_LO   = 5'd12;
    localparam logic [HDR_CNT_W-1:0] HDR_POS_W_HI   = 5'd13;
    localparam logic [HDR_CNT_W-1:0] HDR_POS_H_LO   = 5'd14;
    localparam logic [HDR_CNT_W-1:0] HDR_POS_H_HI   = 5'd15;
    localparam logic [HDR_CNT_W-1:0] HDR_POS_DEPTH  = 5'd16;

    localparam logic [7:0] REQUIRED_DEPTH = 8'd24;
    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_GREY      = 8'd3;
    localparam logic [7:0] ALPHA_VALUE    = 8'hFF;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_PIXELS = 2'd1,
        MODE_SKIP   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_BLUE  = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_RED   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_PIXEL        = 3'd0,
        ST_TRUNC_HEADER = 3'd1,
        ST_BAD_DEPTH    = 3'd2,
        ST_BAD_TYPE     = 3'd3,
        ST_TRUNC_PIXELS = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_item_t;

    typedef struct packed {
        logic       valid;
        byte_item_t item;
    } byte_stage_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] pixel_rgba;
        logic [15:0] column;
        logic [15:0] dest_row;
        logic        last_pixel;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } result_stage_t;

endpackage

`default_nettype wire

// ===== rtl/tgad_byte_if.sv =====
// ----------------------------------------------------------------------------
// tgad_byte_if
// Byte stream channel: one file byte per transfer, with end-of-file mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgad_pix_if.sv =====
// ----------------------------------------------------------------------------
// tgad_pix_if
// Result channel: one pixel or status word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgad_pix_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] pixel_rgba;
    logic [15:0] column;
    logic [15:0] dest_row;
    logic        last_pixel;

    modport source (
        output valid, output status, output pixel_rgba, output column,
        output dest_row, output last_pixel, input ready
    );
    modport sink (
        input valid, input status, input pixel_rgba, input column,
        input dest_row, input last_pixel, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tgad_in_stage.sv =====
// ----------------------------------------------------------------------------
// tgad_in_stage
// Input register for the byte stream; holds one byte until the decoder
// can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tgad_byte_if.sink                 in_ch,
    input  wire logic                 advance,
    output tgad_pkg::byte_stage_t     stage
);

    logic                 valid_reg;
    logic                 valid_next;
    tgad_pkg::byte_item_t item_reg;
    logic                 load;

    assign in_ch.ready = !valid_reg || advance;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte   <= in_ch.data_byte;
            item_reg.end_of_file <= in_ch.end_of_file;
        end
    end

    assign stage = {valid_reg, item_reg};

endmodule

`default_nettype wire

// ===== rtl/tgad_core.sv =====
// ----------------------------------------------------------------------------
// tgad_core
// Header parser and pixel assembler: updates the decode state for one byte
// and forms the result it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tgad_pkg::byte_stage_t  stage,
    input  wire logic                   advance,
    output tgad_pkg::result_stage_t     result
);

    tgad_pkg::mode_t                    mode_reg,  mode_next;
    logic [tgad_pkg::HDR_CNT_W-1:0]     header_count_reg, header_count_next;
    logic [15:0]                        image_width_reg,  image_width_next;
    logic [15:0]                        image_height_reg, image_height_next;
    logic [7:0]                         image_type_reg,   image_type_next;
    logic [7:0]                         depth_reg,        depth_next;
    tgad_pkg::phase_t                   phase_reg,        phase_next;
    logic [15:0]                        held_bg_reg,      held_bg_next;
    logic [15:0]                        column_reg,       column_next;
    logic [15:0]                        file_row_reg,     file_row_next;

    logic        fire;
    logic        eof;
    logic [7:0]  b;
    logic        hdr_done;
    logic        depth_bad;
    logic        type_bad;
    logic        empty_img;
    logic        end_col;
    logic        last;
    logic [15:0] dest_row;

    assign fire      = stage.valid && advance;
    assign eof       = stage.item.end_of_file;
    assign b         = stage.item.data_byte;
    assign hdr_done  = (header_count_reg == tgad_pkg::HDR_LAST_POS);
    assign depth_bad = (depth_reg != tgad_pkg::REQUIRED_DEPTH);
    assign type_bad  = (image_type_reg != tgad_pkg::TYPE_TRUECOLOR)
                    && (image_type_reg != tgad_pkg::TYPE_GREY);
    assign empty_img = (image_width_reg == 16'd0) || (image_height_reg == 16'd0);
    assign end_col   = (column_reg == image_width_reg - 16'd1);
    assign last      = end_col && (file_row_reg == image_height_reg - 16'd1);
    assign dest_row  = image_height_reg - 16'd1 - file_row_reg;

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (fire)
        begin
            if (eof)
            begin
                mode_next = tgad_pkg::MODE_HEADER;
            end
            else
            begin
                case (mode_reg)
                    tgad_pkg::MODE_HEADER:
                    begin
                        if (hdr_done)
                        begin
                            if (depth_bad || type_bad || empty_img)
                            begin
                                mode_next = tgad_pkg::MODE_SKIP;
                            end
                            else
                            begin
                                mode_next = tgad_pkg::MODE_PIXELS;
                            end
                        end
                    end
                    tgad_pkg::MODE_PIXELS:
                    begin
                        if (phase_reg == tgad_pkg::PHASE_RED && last)
                        begin
                            mode_next = tgad_pkg::MODE_SKIP;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    // datapath state and result
    always_comb
    begin
        header_count_next = header_count_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        image_type_next   = image_type_reg;
        depth_next        = depth_reg;
        phase_next        = phase_reg;
        held_bg_next      = held_bg_reg;
        column_next       = column_reg;
        file_row_next     = file_row_reg;

        result.valid          = 1'b0;
        result.res.status     = tgad_pkg::ST_PIXEL;
        result.res.pixel_rgba = 32'd0;
        result.res.column     = 16'd0;
        result.res.dest_row   = 16'd0;
        result.res.last_pixel = 1'b0;

        if (fire)
        begin
            case (mode_reg)
                tgad_pkg::MODE_HEADER:
                begin
                    if (header_count_reg == tgad_pkg::HDR_POS_TYPE)
                    begin
                        image_type_next = b;
                    end
                    if (header_count_reg == tgad_pkg::HDR_POS_W_LO)
                    begin
                        image_width_next = {image_width_reg[15:8], b};
                    end
                    if (header_count_reg == tgad_pkg::HDR_POS_W_HI)
                    begin
                        image_width_next = {b, image_width_reg[7:0]};
                    end
                    if (header_count_reg == tgad_pkg::HDR_POS_H_LO)
                    begin
                        image_height_next = {image_height_reg[15:8], b};
                    end
                    if (header_count_reg == tgad_pkg::HDR_POS_H_HI)
                    begin
                        image_height_next = {b, image_height_reg[7:0]};
                    end
                    if (header_count_reg == tgad_pkg::HDR_POS_DEPTH)
                    begin
                        depth_next = b;
                    end

                    if (!hdr_done)
                    begin
                        header_count_next = header_count_reg + 1'b1;
                        if (eof)
                        begin
                            result.valid      = 1'b1;
                            result.res.status = tgad_pkg::ST_TRUNC_HEADER;
                        end
                    end
                    else
                    begin
                        header_count_next = tgad_pkg::HDR_DONE_COUNT;
                        phase_next        = tgad_pkg::PHASE_BLUE;
                        column_next       = 16'd0;
                        file_row_next     = 16'd0;
                        if (depth_bad)
                        begin
                            result.valid      = 1'b1;
                            result.res.status = tgad_pkg::ST_BAD_DEPTH;
                        end
                        else if (type_bad)
                        begin
                            result.valid      = 1'b1;
                            result.res.status = tgad_pkg::ST_BAD_TYPE;
                        end
                        else if (!empty_img && eof)
                        begin
                            result.valid      = 1'b1;
                            result.res.status = tgad_pkg::ST_TRUNC_PIXELS;
                        end
                    end
                end
                tgad_pkg::MODE_PIXELS:
                begin
                    case (phase_reg)
                        tgad_pkg::PHASE_BLUE:
                        begin
                            held_bg_next = {b, 8'd0};
                            phase_next   = tgad_pkg::PHASE_GREEN;
                        end
                        tgad_pkg::PHASE_GREEN:
                        begin
                            held_bg_next = {held_bg_reg[15:8], b};
                            phase_next   = tgad_pkg::PHASE_RED;
                        end
                        default:
                        begin
                            phase_next = tgad_pkg::PHASE_BLUE;
                            if (end_col)
                            begin
                                column_next   = 16'd0;
                                file_row_next = file_row_reg + 16'd1;
                            end
                            else
                            begin
                                column_next = column_reg + 16'd1;
                            end
                        end
                    endcase

                    if (phase_reg == tgad_pkg::PHASE_RED && (last || !eof))
                    begin
                        result.valid          = 1'b1;
                        result.res.status     = tgad_pkg::ST_PIXEL;
                        result.res.pixel_rgba = {b, held_bg_reg[7:0], held_bg_reg[15:8],
                                                 tgad_pkg::ALPHA_VALUE};
                        result.res.column     = column_reg;
                        result.res.dest_row   = dest_row;
                        result.res.last_pixel = last;
                    end
                    else if (eof)
                    begin
                        result.valid      = 1'b1;
                        result.res.status = tgad_pkg::ST_TRUNC_PIXELS;
                    end
                end
                default:
                begin
                    header_count_next = header_count_reg;
                end
            endcase

            // end of file returns everything to the post-reset state
            if (eof)
            begin
                header_count_next = '0;
                image_width_next  = 16'd0;
                image_height_next = 16'd0;
                image_type_next   = 8'd0;
                depth_next        = 8'd0;
                phase_next        = tgad_pkg::PHASE_BLUE;
                held_bg_next      = 16'd0;
                column_next       = 16'd0;
                file_row_next     = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= tgad_pkg::MODE_HEADER;
            header_count_reg <= '0;
            image_width_reg  <= 16'd0;
            image_height_reg <= 16'd0;
            image_type_reg   <= 8'd0;
            depth_reg        <= 8'd0;
            phase_reg        <= tgad_pkg::PHASE_BLUE;
            held_bg_reg      <= 16'd0;
            column_reg       <= 16'd0;
            file_row_reg     <= 16'd0;
        end
        else
        begin
            mode_reg         <= mode_next;
            header_count_reg <= header_count_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            image_type_reg   <= image_type_next;
            depth_reg        <= depth_next;
            phase_reg        <= phase_next;
            held_bg_reg      <= held_bg_next;
            column_reg       <= column_next;
            file_row_reg     <= file_row_next;
        end
    end

    a_pixels_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == tgad_pkg::MODE_PIXELS |-> header_count_reg == tgad_pkg::HDR_DONE_COUNT)
        else $error("pixel mode entered without a complete header");

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eof |=> mode_reg == tgad_pkg::MODE_HEADER && header_count_reg == '0
                        && phase_reg == tgad_pkg::PHASE_BLUE)
        else $error("end of file did not return to header parsing");

    a_pixel_on_red: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.res.status == tgad_pkg::ST_PIXEL
            |-> mode_reg == tgad_pkg::MODE_PIXELS && phase_reg == tgad_pkg::PHASE_RED)
        else $error("pixel result outside the third byte of a pixel");

    a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> fire)
        else $error("result produced without a byte transfer");

    a_last_leaves_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.res.last_pixel |=> mode_reg != tgad_pkg::MODE_PIXELS)
        else $error("decoder stayed in pixel mode after the final pixel");

endmodule

`default_nettype wire

// ===== rtl/tgad_out_stage.sv =====
// ----------------------------------------------------------------------------
// tgad_out_stage
// Result register driving the output channel; frees the decoder whenever
// the register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_out_stage (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tgad_pkg::result_stage_t  result,
    output logic                          advance,
    tgad_pix_if.source                    out_ch
);

    logic              valid_reg;
    logic              valid_next;
    tgad_pkg::result_t res_reg;

    assign advance = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            res_reg <= result.res;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.status     = res_reg.status;
    assign out_ch.pixel_rgba = res_reg.pixel_rgba;
    assign out_ch.column     = res_reg.column;
    assign out_ch.dest_row   = res_reg.dest_row;
    assign out_ch.last_pixel = res_reg.last_pixel;

endmodule

`default_nettype wire

// ===== rtl/tga_rgb24_stream_decoder.sv =====
// Path: a transferred byte lands in the input register; its result is
//   loaded into the result register once that register is empty or draining.
// Throughput: one byte per cycle, sustained while the output side is ready;
//   the decoder state updates once per byte.
// Reset: rst_n clears all decode state to header parsing and empties both
//   registers; no result is pending after reset.
// ----------------------------------------------------------------------------
// tga_rgb24_stream_decoder
// Uncompressed 24-bit TGA decoder: parses the 18-byte header, then turns
// blue/green/red byte triples into RGBA pixels tagged with column and
// bottom-up flipped row, or reports a status for bad or truncated files.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rgb24_stream_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tgad_byte_if.sink   in_ch,
    tgad_pix_if.source  out_ch
);

    tgad_pkg::byte_stage_t   stage;
    tgad_pkg::result_stage_t result;
    logic                    advance;

    tgad_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .stage   (stage)
    );

    tgad_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    tgad_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .advance (advance),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TGA 24-bit stream decoder. Whole files are fed
// in a byte at a time: short directed files for header errors, empty images,
// truncation and extreme sizes, then random files, mostly well formed. A
// behavioural decoder predicts each result; results are checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FILL_RANDOM  = -1;

    logic clk;
    logic rst_n;

    tgad_byte_if in_ch();
    tgad_pix_if  out_ch();

    tga_rgb24_stream_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // decoder model state
    tgad_pkg::mode_t  dec_mode   = tgad_pkg::MODE_HEADER;
    logic [4:0]       hdr_count  = '0;
    logic [15:0]      img_width  = '0;
    logic [15:0]      img_height = '0;
    logic [7:0]       img_type   = '0;
    logic [7:0]       img_depth  = '0;
    tgad_pkg::phase_t dec_phase  = tgad_pkg::PHASE_BLUE;
    logic [15:0]      held_bg    = '0;
    logic [15:0]      col_count  = '0;
    logic [15:0]      row_count  = '0;

    tgad_pkg::result_t expected_pixels[$];

    int  error_count = 0;
    int  sent_bytes  = 0;
    int  hold_cycles = 0;
    int  cycle_count = 0;
    bit  idling      = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: long hold-off, random stall bursts, otherwise ready
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        tgad_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result transfer: status %0d", out_ch.status);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.pixel_rgba !== want.pixel_rgba)
                begin
                    $error("pixel_rgba: expected %h, actual %h",
                           want.pixel_rgba, out_ch.pixel_rgba);
                    error_count++;
                end
                if (out_ch.column !== want.column)
                begin
                    $error("column: expected %0d, actual %0d", want.column, out_ch.column);
                    error_count++;
                end
                if (out_ch.dest_row !== want.dest_row)
                begin
                    $error("dest_row: expected %0d, actual %0d",
                           want.dest_row, out_ch.dest_row);
                    error_count++;
                end
                if (out_ch.last_pixel !== want.last_pixel)
                begin
                    $error("last_pixel: expected %0b, actual %0b",
                           want.last_pixel, out_ch.last_pixel);
                    error_count++;
                end
            end
        end
    end

    task automatic clear_decoder();
        dec_mode   = tgad_pkg::MODE_HEADER;
        hdr_count  = '0;
        img_width  = '0;
        img_height = '0;
        img_type   = '0;
        img_depth  = '0;
        dec_phase  = tgad_pkg::PHASE_BLUE;
        held_bg    = '0;
        col_count  = '0;
        row_count  = '0;
    endtask

    task automatic push_result(input tgad_pkg::status_t st, input logic [31:0] rgba,
                               input logic [15:0] col, input logic [15:0] row,
                               input logic last);
        tgad_pkg::result_t r;
        r.status     = st;
        r.pixel_rgba = rgba;
        r.column     = col;
        r.dest_row   = row;
        r.last_pixel = last;
        expected_pixels.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eof);
        logic [31:0] rgba;
        logic [15:0] col;
        logic [15:0] row;
        logic        end_col;
        logic        last;
        bit          type_ok;
        bit          depth_ok;
        case (dec_mode)
            tgad_pkg::MODE_HEADER:
            begin
                if (hdr_count == tgad_pkg::HDR_POS_TYPE)       img_type = b;
                else if (hdr_count == tgad_pkg::HDR_POS_W_LO)  img_width[7:0] = b;
                else if (hdr_count == tgad_pkg::HDR_POS_W_HI)  img_width[15:8] = b;
                else if (hdr_count == tgad_pkg::HDR_POS_H_LO)  img_height[7:0] = b;
                else if (hdr_count == tgad_pkg::HDR_POS_H_HI)  img_height[15:8] = b;
                else if (hdr_count == tgad_pkg::HDR_POS_DEPTH) img_depth = b;

                if (hdr_count < tgad_pkg::HDR_LAST_POS)
                begin
                    hdr_count = hdr_count + 5'd1;
                    if (eof)
                    begin
                        clear_decoder();
                        push_result(tgad_pkg::ST_TRUNC_HEADER, '0, '0, '0, 1'b0);
                    end
                end
                else
                begin
                    hdr_count = tgad_pkg::HDR_DONE_COUNT;
                    type_ok  = (img_type == tgad_pkg::TYPE_TRUECOLOR) ||
                               (img_type == tgad_pkg::TYPE_GREY);
                    depth_ok = (img_depth == tgad_pkg::REQUIRED_DEPTH);
                    if (!depth_ok || !type_ok ||
                        img_width == 16'd0 || img_height == 16'd0)
                    begin
                        if (!depth_ok)
                            push_result(tgad_pkg::ST_BAD_DEPTH, '0, '0, '0, 1'b0);
                        else if (!type_ok)
                            push_result(tgad_pkg::ST_BAD_TYPE, '0, '0, '0, 1'b0);
                        if (eof)
                            clear_decoder();
                        else
                            dec_mode = tgad_pkg::MODE_SKIP;
                    end
                    else if (eof)
                    begin
                        clear_decoder();
                        push_result(tgad_pkg::ST_TRUNC_PIXELS, '0, '0, '0, 1'b0);
                    end
                    else
                    begin
                        dec_mode  = tgad_pkg::MODE_PIXELS;
                        dec_phase = tgad_pkg::PHASE_BLUE;
                        col_count = '0;
                        row_count = '0;
                    end
                end
            end
            tgad_pkg::MODE_PIXELS:
            begin
                if (dec_phase == tgad_pkg::PHASE_BLUE || dec_phase == tgad_pkg::PHASE_GREEN)
                begin
                    if (dec_phase == tgad_pkg::PHASE_BLUE)
                    begin
                        held_bg   = {b, 8'h00};
                        dec_phase = tgad_pkg::PHASE_GREEN;
                    end
                    else
                    begin
                        held_bg[7:0] = b;
                        dec_phase    = tgad_pkg::PHASE_RED;
                    end
                    if (eof)
                    begin
                        clear_decoder();
                        push_result(tgad_pkg::ST_TRUNC_PIXELS, '0, '0, '0, 1'b0);
                    end
                end
                else
                begin
                    rgba      = {b, held_bg[7:0], held_bg[15:8], tgad_pkg::ALPHA_VALUE};
                    col       = col_count;
                    row       = img_height - 16'd1 - row_count;
                    end_col   = (col_count == img_width - 16'd1);
                    last      = end_col && (row_count == img_height - 16'd1);
                    dec_phase = tgad_pkg::PHASE_BLUE;
                    if (eof)
                    begin
                        clear_decoder();
                        if (last)
                            push_result(tgad_pkg::ST_PIXEL, rgba, col, row, 1'b1);
                        else
                            push_result(tgad_pkg::ST_TRUNC_PIXELS, '0, '0, '0, 1'b0);
                    end
                    else
                    begin
                        if (last)
                            dec_mode = tgad_pkg::MODE_SKIP;
                        else if (end_col)
                        begin
                            col_count = '0;
                            row_count = row_count + 16'd1;
                        end
                        else
                            col_count = col_count + 16'd1;
                        push_result(tgad_pkg::ST_PIXEL, rgba, col, row, last);
                    end
                end
            end
            default:
            begin
                if (eof)
                    clear_decoder();
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.data_byte   = b;
        in_ch.end_of_file = eof;
        do
            @(posedge clk);
        while (!in_ch.ready);
        decode_byte(b, eof);
        sent_bytes++;
    endtask

    // len bytes in all, end of file on the last; fill < 0 gives random pixel bytes
    task automatic send_file(input logic [7:0] t, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] dep,
                             input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i == tgad_pkg::HDR_POS_TYPE)       b = t;
            else if (i == tgad_pkg::HDR_POS_W_LO)  b = w[7:0];
            else if (i == tgad_pkg::HDR_POS_W_HI)  b = w[15:8];
            else if (i == tgad_pkg::HDR_POS_H_LO)  b = h[7:0];
            else if (i == tgad_pkg::HDR_POS_H_HI)  b = h[15:8];
            else if (i == tgad_pkg::HDR_POS_DEPTH) b = dep;
            else if (i >= tgad_pkg::HDR_DONE_COUNT && fill >= 0) b = fill[7:0];
            else                                   b = 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_file();
        logic [7:0]  t;
        logic [7:0]  dep;
        logic [15:0] w;
        logic [15:0] h;
        int          len;
        int          full;
        int          kind;
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            t   = $urandom_range(0, 1) ? tgad_pkg::TYPE_TRUECOLOR : tgad_pkg::TYPE_GREY;
            dep = tgad_pkg::REQUIRED_DEPTH;
            if ($urandom_range(0, 19) == 0)
            begin
                w   = 16'($urandom_range(1, 16'hFFFF));
                h   = 16'($urandom_range(1, 16'hFFFF));
                len = tgad_pkg::HDR_DONE_COUNT + $urandom_range(0, 12);
            end
            else
            begin
                w    = 16'($urandom_range(1, 6));
                h    = 16'($urandom_range(1, 5));
                full = tgad_pkg::HDR_DONE_COUNT + 3 * w * h;
                kind = $urandom_range(0, 9);
                if (kind < 6)
                    len = full;
                else if (kind < 8)
                    len = full + $urandom_range(1, 6);
                else
                    len = $urandom_range(tgad_pkg::HDR_DONE_COUNT, full - 1);
            end
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       t = tgad_pkg::TYPE_TRUECOLOR;
                1:       t = tgad_pkg::TYPE_GREY;
                default: t = 8'($urandom_range(0, 255));
            endcase
            dep = $urandom_range(0, 1) ? tgad_pkg::REQUIRED_DEPTH
                                       : 8'($urandom_range(0, 255));
            w   = 16'($urandom_range(0, 3));
            h   = 16'($urandom_range(0, 3));
            len = $urandom_range(1, 36);
        end
        send_file(t, w, h, dep, len, FILL_RANDOM);
    endtask

    task automatic test_header_errors();
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  1, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  17, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd32, 18, FILL_RANDOM);
        send_file(8'd0, 16'd2, 16'd2, 8'd0, 25, FILL_RANDOM);
        send_file(8'd10, 16'd2, 16'd2, tgad_pkg::REQUIRED_DEPTH, 20, FILL_RANDOM);
        send_file(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 18, FILL_RANDOM);
        send_file(8'hFF, 16'd1, 16'd1, tgad_pkg::REQUIRED_DEPTH, 22, FILL_RANDOM);
    endtask

    task automatic test_empty_images();
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd0, 16'd5, tgad_pkg::REQUIRED_DEPTH,
                  30, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_GREY, 16'd4, 16'd0, tgad_pkg::REQUIRED_DEPTH,
                  18, FILL_RANDOM);
    endtask

    task automatic test_pixel_images();
        send_file(tgad_pkg::TYPE_GREY, 16'd2, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  18, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  30, 255);
        send_file(tgad_pkg::TYPE_GREY, 16'd1, 16'd2, tgad_pkg::REQUIRED_DEPTH, 24, 0);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, tgad_pkg::REQUIRED_DEPTH,
                  26, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd3, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  22, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd3, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  23, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd3, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  24, FILL_RANDOM);
        send_file(tgad_pkg::TYPE_GREY, 16'hFFFF, 16'hFFFF, tgad_pkg::REQUIRED_DEPTH,
                  31, FILL_RANDOM);
    endtask

    // receiver held off while the first part of a whole image is offered
    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 300;
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd8, 16'd4, tgad_pkg::REQUIRED_DEPTH,
                  tgad_pkg::HDR_DONE_COUNT + 3 * 8 * 4, FILL_RANDOM);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_file(tgad_pkg::TYPE_GREY, 16'd3, 16'd2, tgad_pkg::REQUIRED_DEPTH,
                  tgad_pkg::HDR_DONE_COUNT + 3 * 3 * 2, FILL_RANDOM);
        wait_drained();
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd3, tgad_pkg::REQUIRED_DEPTH,
                  tgad_pkg::HDR_DONE_COUNT + 3 * 2 * 3 + 2, FILL_RANDOM);
    endtask

    task automatic test_random_files(input int n_bytes);
        int stop_at;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at)
        begin
            idling = ($urandom_range(0, 3) != 0);
            send_random_file();
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end
    endtask

    task automatic test_quiet_tail(input int n_bytes);
        int stop_at;
        idling  = 1'b0;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at)
            send_random_file();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.end_of_file = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_header_errors();
        test_empty_images();
        test_pixel_images();
        test_backpressure();
        test_drain_pause();
        test_random_files(550);
        test_quiet_tail(100);
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tgad_pkg.sv
rtl/tgad_byte_if.sv
rtl/tgad_pix_if.sv
rtl/tgad_in_stage.sv
rtl/tgad_core.sv
rtl/tgad_out_stage.sv
rtl/tga_rgb24_stream_decoder.sv
sim/tb_top.sv
